// ----- design/lsfd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_pkg
// shared types, codes and reset values of the serial frame deframer
// ----------------------------------------------------------------------------
package lsfd_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_HEADER_FIRST     = 3'd0;
   localparam logic [2:0] CSR_HEADER_SECOND    = 3'd1;
   localparam logic [2:0] CSR_OPCODE_REG_WRITE = 3'd2;
   localparam logic [2:0] CSR_OPCODE_REG_READ  = 3'd3;
   localparam logic [2:0] CSR_OPCODE_VAR_WRITE = 3'd4;
   localparam logic [2:0] CSR_OPCODE_VAR_READ  = 3'd5;

   // register reset values
   localparam logic [7:0] RST_HEADER_FIRST     = 8'h5A;
   localparam logic [7:0] RST_HEADER_SECOND    = 8'hA5;
   localparam logic [7:0] RST_OPCODE_REG_WRITE = 8'h80;
   localparam logic [7:0] RST_OPCODE_REG_READ  = 8'h81;
   localparam logic [7:0] RST_OPCODE_VAR_WRITE = 8'h82;
   localparam logic [7:0] RST_OPCODE_VAR_READ  = 8'h83;

   // result kinds
   localparam logic [2:0] KIND_DATA     = 3'd0;
   localparam logic [2:0] KIND_ACK      = 3'd1;
   localparam logic [2:0] KIND_VAR_DONE = 3'd2;
   localparam logic [2:0] KIND_REG_DONE = 3'd3;
   localparam logic [2:0] KIND_OTHER    = 3'd4;

   // payload "OK" of an acknowledge
   localparam logic [15:0] ACK_WORD = 16'h4F4B;

   // result queue depth, power of two and at least two
   localparam int RSP_QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] opcode_reg_write;
      logic [7:0] opcode_reg_read;
      logic [7:0] opcode_var_write;
      logic [7:0] opcode_var_read;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] addr;
      logic [15:0] value;
      logic [7:0]  count;
      logic [7:0]  cmd;
      logic        short_flag;
      logic        last;
   } result_type;

   // up to two results from one byte; when only one, it is in slot 0
   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } push_type;

endpackage
`default_nettype wire

// ----- design/lsfd_parse.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_parse
// frame state machine: one received byte per cycle while byte_fire is high, up to two results
// ----------------------------------------------------------------------------
module lsfd_parse (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  byte_fire,
   input  wire [7:0]            rx_byte,
   input  wire lsfd_pkg::cfg_type cfg,
   output lsfd_pkg::push_type   push
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_SECOND  = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_CMD     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  frame_len_ff, frame_len_in;
   logic [7:0]  frame_cmd_ff, frame_cmd_in;
   logic [7:0]  payload_index_ff, payload_index_in;
   logic [15:0] reply_addr_ff, reply_addr_in;
   logic [7:0]  reply_count_ff, reply_count_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic [7:0]  elements_sent_ff, elements_sent_in;
   logic [15:0] first_two_ff, first_two_in;

   logic [7:0]  total;
   logic [8:0]  index_next;
   logic        var_r;
   logic        reg_r;
   logic        emit;
   logic        frame_end;
   logic        ack_ok;
   lsfd_pkg::result_type elem_res;
   lsfd_pkg::result_type done_res;

   always_comb begin
      phase_in         = phase_ff;
      frame_len_in     = frame_len_ff;
      frame_cmd_in     = frame_cmd_ff;
      payload_index_in = payload_index_ff;
      reply_addr_in    = reply_addr_ff;
      reply_count_in   = reply_count_ff;
      held_byte_in     = held_byte_ff;
      elements_sent_in = elements_sent_ff;
      first_two_in     = first_two_ff;
      emit             = 1'b0;
      frame_end        = 1'b0;
      ack_ok           = 1'b0;

      total      = (frame_len_ff <= 8'd1) ? 8'd1 : frame_len_ff - 8'd1;
      index_next = {1'b0, payload_index_ff} + 9'd1;
      var_r      = (frame_cmd_ff == cfg.opcode_var_read);
      reg_r      = !var_r && (frame_cmd_ff == cfg.opcode_reg_read);

      elem_res            = '0;
      elem_res.kind       = lsfd_pkg::KIND_DATA;
      elem_res.addr       = reply_addr_ff;
      elem_res.value      = var_r ? {held_byte_ff, rx_byte} : {8'h00, rx_byte};
      elem_res.count      = reply_count_ff;
      elem_res.cmd        = frame_cmd_ff;

      unique case (phase_ff)
         PH_SECOND: begin
            phase_in = (rx_byte == cfg.header_second || rx_byte == 8'h00) ? PH_LEN : PH_HUNT;
         end
         PH_LEN: begin
            frame_len_in     = rx_byte;
            frame_cmd_in     = '0;
            payload_index_in = '0;
            reply_addr_in    = '0;
            reply_count_in   = '0;
            held_byte_in     = '0;
            elements_sent_in = '0;
            first_two_in     = '0;
            phase_in         = PH_CMD;
         end
         PH_CMD: begin
            frame_cmd_in = rx_byte;
            phase_in     = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if (payload_index_ff == 8'd0) begin
               first_two_in = {rx_byte, 8'h00};
            end else if (payload_index_ff == 8'd1) begin
               first_two_in = {first_two_ff[15:8], rx_byte};
            end

            if (var_r) begin
               if (payload_index_ff == 8'd0) begin
                  reply_addr_in = {rx_byte, 8'h00};
               end else if (payload_index_ff == 8'd1) begin
                  reply_addr_in = {reply_addr_ff[15:8], rx_byte};
               end else if (payload_index_ff == 8'd2) begin
                  reply_count_in = rx_byte;
               end else if (payload_index_ff[0]) begin
                  // high byte of a data word
                  held_byte_in = rx_byte;
               end else if (elements_sent_ff < reply_count_ff) begin
                  emit = 1'b1;
               end
            end else if (reg_r) begin
               if (payload_index_ff == 8'd0) begin
                  reply_addr_in = {8'h00, rx_byte};
               end else if (payload_index_ff == 8'd1) begin
                  reply_count_in = rx_byte;
               end else if (elements_sent_ff < reply_count_ff) begin
                  emit = 1'b1;
               end
            end

            if (emit) begin
               elements_sent_in = elements_sent_ff + 8'd1;
            end

            payload_index_in = index_next[7:0];
            frame_end        = (index_next >= {1'b0, total});
            ack_ok = (total == 8'd2)
                     && (frame_cmd_ff == cfg.opcode_var_write
                         || frame_cmd_ff == cfg.opcode_reg_write)
                     && (first_two_in == lsfd_pkg::ACK_WORD);
         end
         default: begin
            phase_in = (rx_byte == cfg.header_first) ? PH_SECOND : PH_HUNT;
         end
      endcase

      // completion uses this byte's updated reply fields
      done_res      = '0;
      done_res.cmd  = frame_cmd_ff;
      done_res.last = 1'b1;
      if (ack_ok) begin
         done_res.kind = lsfd_pkg::KIND_ACK;
      end else if (var_r || reg_r) begin
         done_res.kind       = var_r ? lsfd_pkg::KIND_VAR_DONE : lsfd_pkg::KIND_REG_DONE;
         done_res.addr       = reply_addr_in;
         done_res.count      = reply_count_in;
         done_res.short_flag = (elements_sent_in < reply_count_in);
      end else begin
         done_res.kind = lsfd_pkg::KIND_OTHER;
      end

      if (frame_end) begin
         phase_in         = PH_HUNT;
         frame_len_in     = '0;
         frame_cmd_in     = '0;
         payload_index_in = '0;
         reply_addr_in    = '0;
         reply_count_in   = '0;
         held_byte_in     = '0;
         elements_sent_in = '0;
         first_two_in     = '0;
      end

      push.valid0 = byte_fire && (emit || frame_end);
      push.valid1 = byte_fire && emit && frame_end;
      push.res0   = emit ? elem_res : done_res;
      push.res1   = done_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         frame_len_ff     <= '0;
         frame_cmd_ff     <= '0;
         payload_index_ff <= '0;
         reply_addr_ff    <= '0;
         reply_count_ff   <= '0;
         held_byte_ff     <= '0;
         elements_sent_ff <= '0;
         first_two_ff     <= '0;
      end else if (byte_fire) begin
         phase_ff         <= phase_in;
         frame_len_ff     <= frame_len_in;
         frame_cmd_ff     <= frame_cmd_in;
         payload_index_ff <= payload_index_in;
         reply_addr_ff    <= reply_addr_in;
         reply_count_ff   <= reply_count_in;
         held_byte_ff     <= held_byte_in;
         elements_sent_ff <= elements_sent_in;
         first_two_ff     <= first_two_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/lsfd_rsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsfd_rsp_queue
// small result queue, takes up to two results a cycle, gives one unless out_stall is high
// ----------------------------------------------------------------------------
module lsfd_rsp_queue #(
   parameter int DEPTH = lsfd_pkg::RSP_QUEUE_DEPTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire lsfd_pkg::push_type push,
   input  wire                  out_stall,
   output logic                 out_valid,
   output lsfd_pkg::result_type out_res,
   output logic                 no_room
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   lsfd_pkg::result_type entries_ff [DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] push_n;
   logic               pop;

   assign out_valid = (count_ff != '0);
   assign out_res   = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && !out_stall;
   // room must exist for two results before a byte is taken
   assign no_room   = (count_ff > COUNT_W'(DEPTH - 2));

   assign push_n    = COUNT_W'(push.valid0) + COUNT_W'(push.valid1);
   assign count_in  = count_ff + push_n - COUNT_W'(pop);
   assign wr_ptr_in = wr_ptr_ff + push_n[PTR_W-1:0];
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entries_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.valid1) begin
         entries_ff[wr_ptr_ff + PTR_W'(1)] <= push.res1;
      end
   end

endmodule
`default_nettype wire

// ----- design/lcd_serial_frame_deframer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_serial_frame_deframer_core
// deframes received display-link bytes into data, ack and completion results
// ----------------------------------------------------------------------------
//  channel  dir  handshake              beat contents
//  req      in   req_valid/req_stall    one received byte
//  rsp      out  rsp_valid/rsp_stall    one result (data element or completion)
//  csr      in   csr_write              register index and 8-bit value
//
//  one byte a cycle while req_stall is low: the parser registers the frame state
//  a byte gives up to two results, which go through a result queue
//  req_stall rises only while the queue lacks room for two results
//  synchronous active-high reset: hunting, queue empty, registers at defaults
//  an accepted byte's results are written into the result queue behind up to
//  two older results, and wait longer while rsp_stall is high
// ----------------------------------------------------------------------------
module lcd_serial_frame_deframer_core #(
   parameter int RSP_DEPTH = lsfd_pkg::RSP_QUEUE_DEPTH
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_res_kind,
   output logic [15:0] rsp_res_addr,
   output logic [15:0] rsp_res_value,
   output logic [7:0]  rsp_res_count,
   output logic [7:0]  rsp_res_cmd,
   output logic        rsp_res_short,
   output logic        rsp_res_last,

   input  wire         csr_write,
   input  wire  [2:0]  csr_index,
   input  wire  [7:0]  csr_data
);

   lsfd_pkg::cfg_type    cfg_ff, cfg_in;
   lsfd_pkg::push_type   push;
   lsfd_pkg::result_type head;
   logic                 no_room;
   logic                 req_fire;

   // configuration registers, unknown indexes dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            lsfd_pkg::CSR_HEADER_FIRST:     cfg_in.header_first     = csr_data;
            lsfd_pkg::CSR_HEADER_SECOND:    cfg_in.header_second    = csr_data;
            lsfd_pkg::CSR_OPCODE_REG_WRITE: cfg_in.opcode_reg_write = csr_data;
            lsfd_pkg::CSR_OPCODE_REG_READ:  cfg_in.opcode_reg_read  = csr_data;
            lsfd_pkg::CSR_OPCODE_VAR_WRITE: cfg_in.opcode_var_write = csr_data;
            lsfd_pkg::CSR_OPCODE_VAR_READ:  cfg_in.opcode_var_read  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first     <= lsfd_pkg::RST_HEADER_FIRST;
         cfg_ff.header_second    <= lsfd_pkg::RST_HEADER_SECOND;
         cfg_ff.opcode_reg_write <= lsfd_pkg::RST_OPCODE_REG_WRITE;
         cfg_ff.opcode_reg_read  <= lsfd_pkg::RST_OPCODE_REG_READ;
         cfg_ff.opcode_var_write <= lsfd_pkg::RST_OPCODE_VAR_WRITE;
         cfg_ff.opcode_var_read  <= lsfd_pkg::RST_OPCODE_VAR_READ;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input beat taken only with room for a data element plus a completion
   assign req_stall = no_room;
   assign req_fire  = req_valid && !no_room;

   lsfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (req_fire),
      .rx_byte   (req_rx_byte),
      .cfg       (cfg_ff),
      .push      (push)
   );

   lsfd_rsp_queue #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_res   (head),
      .no_room   (no_room)
   );

   assign rsp_res_kind  = head.kind;
   assign rsp_res_addr  = head.addr;
   assign rsp_res_value = head.value;
   assign rsp_res_count = head.count;
   assign rsp_res_cmd   = head.cmd;
   assign rsp_res_short = head.short_flag;
   assign rsp_res_last  = head.last;

   // input stalls only because results are waiting
   a_stall_has_backlog: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty result queue");

   // every beat that is not a completion is a data element
   a_nonlast_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_res_last |-> rsp_res_kind == lsfd_pkg::KIND_DATA)
      else $error("non-final result with completion kind");

   // short flag only on completions
   a_short_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_res_short |-> rsp_res_last
         && (rsp_res_kind == lsfd_pkg::KIND_VAR_DONE
             || rsp_res_kind == lsfd_pkg::KIND_REG_DONE))
      else $error("short flag outside a read completion");

   // a push of two always carries a data element first
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.valid1 |-> push.valid0 && !push.res0.last && push.res1.last)
      else $error("result pair out of order");

endmodule
`default_nettype wire
